// ----- sv/urrm_pkg.sv -----
// ----------------------------------------------------------------------------
// urrm_pkg - shared types, constants and arithmetic helpers
// Fixed-point formats, CORDIC angle table, rounding multiply and output
// conversion for the uniform random rotation matrix unit.
// ----------------------------------------------------------------------------
package urrm_pkg;

	localparam int RAND_BITS     = 16;
	localparam int OUT_FRAC_BITS = 14;
	localparam int FIELD_W       = 16;
	localparam int Q             = 30;
	localparam int CORDIC_STEPS  = 24;
	localparam int SQRT_STEPS    = 32;
	localparam int CORDIC_PAD    = SQRT_STEPS - CORDIC_STEPS - 1;
	localparam int FRONT_DEPTH   = 1 + SQRT_STEPS;
	localparam int LATENCY       = FRONT_DEPTH + 5;
	localparam int OUT_SHIFT     = Q - OUT_FRAC_BITS;

	localparam logic [30:0]        HALF_PI_Q   = 31'd1686629713;
	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [35:0] OUT_LIM     = 36'sd1 <<< OUT_FRAC_BITS;

	typedef logic signed [31:0] q30_t;
	typedef logic [8:0][FIELD_W-1:0] mat_t;

	// arctan(2^-i) in Q.30; small angles are just 2^-i
	function automatic logic signed [32:0] cordic_angle(input int i);
		logic signed [32:0] a;
		case (i)
			0:       a = 33'sd843314857;
			1:       a = 33'sd497837829;
			2:       a = 33'sd263043837;
			3:       a = 33'sd133525159;
			4:       a = 33'sd67021687;
			5:       a = 33'sd33543516;
			6:       a = 33'sd16775851;
			7:       a = 33'sd8388437;
			8:       a = 33'sd4194283;
			9:       a = 33'sd2097149;
			10:      a = 33'sd1048576;
			default: a = 33'sd1 <<< (Q - i);
		endcase
		return a;
	endfunction

	// Q.30 product, magnitude rounded half away from zero
	function automatic q30_t mulq(input q30_t a, input q30_t b);
		logic [31:0] ma;
		logic [31:0] mb;
		logic [63:0] p;
		logic [33:0] r;
		ma = a[31] ? (~a + 32'd1) : a;
		mb = b[31] ? (~b + 32'd1) : b;
		p  = 64'(ma) * 64'(mb);
		p  = p + (64'd1 << (Q - 1));
		r  = 34'(p >> Q);
		return (a[31] ^ b[31]) ? q30_t'(-$signed({1'b0, r})) : q30_t'($signed({1'b0, r}));
	endfunction

	// round Q.30 to the output format, saturate, keep the field width
	function automatic logic [FIELD_W-1:0] to_out(input logic signed [33:0] v);
		logic [33:0]        m;
		logic signed [35:0] o;
		m = v[33] ? (~v + 34'd1) : v;
		if (OUT_SHIFT > 0)
			m = (m + (34'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
		o = v[33] ? -$signed({2'b00, m}) : $signed({2'b00, m});
		if (o > OUT_LIM)
			o = OUT_LIM;
		if (o < -OUT_LIM)
			o = -OUT_LIM;
		return o[FIELD_W-1:0];
	endfunction

endpackage

// ----- sv/urrm_cordic.sv -----
// ----------------------------------------------------------------------------
// urrm_cordic - pipelined sine/cosine of a turn fraction
// Angle scaling stage, one CORDIC rotation per stage, quadrant fix-up and
// a delay line that aligns the result with the square root pipelines.
// ----------------------------------------------------------------------------
module urrm_cordic (
	input  logic                          clk,
	input  logic                          en,
	input  logic [urrm_pkg::RAND_BITS-1:0] turn,
	output urrm_pkg::q30_t                sin_v,
	output urrm_pkg::q30_t                cos_v
);
	import urrm_pkg::*;

	logic [31:0]        turn_a;
	logic [60:0]        ang_prod;
	logic signed [32:0] x_s [CORDIC_STEPS+1];
	logic signed [32:0] y_s [CORDIC_STEPS+1];
	logic signed [32:0] z_s [CORDIC_STEPS];
	logic [1:0]         quad_s [CORDIC_STEPS+1];
	q30_t               sin_s [CORDIC_PAD+1];
	q30_t               cos_s [CORDIC_PAD+1];

	assign turn_a   = 32'(turn) << (32 - RAND_BITS);
	assign ang_prod = 61'(turn_a[29:0]) * 61'(HALF_PI_Q);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= CORDIC_GAIN;
			y_s[0]    <= '0;
			z_s[0]    <= $signed({2'b00, ang_prod[60:30]});
			quad_s[0] <= turn_a[31:30];
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [32:0] ANG = cordic_angle(i);
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][32]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				end
				quad_s[i+1] <= quad_s[i];
			end
		end
		if (i + 1 < CORDIC_STEPS) begin : g_z
			always_ff @(posedge clk) begin
				if (en)
					z_s[i+1] <= z_s[i][32] ? z_s[i] + ANG : z_s[i] - ANG;
			end
		end
	end

	// fold the quadrant back in by swap and negate
	always_ff @(posedge clk) begin
		if (en) begin
			case (quad_s[CORDIC_STEPS])
				2'd0: begin
					cos_s[0] <= q30_t'(x_s[CORDIC_STEPS]);
					sin_s[0] <= q30_t'(y_s[CORDIC_STEPS]);
				end
				2'd1: begin
					cos_s[0] <= q30_t'(-y_s[CORDIC_STEPS]);
					sin_s[0] <= q30_t'(x_s[CORDIC_STEPS]);
				end
				2'd2: begin
					cos_s[0] <= q30_t'(-x_s[CORDIC_STEPS]);
					sin_s[0] <= q30_t'(-y_s[CORDIC_STEPS]);
				end
				default: begin
					cos_s[0] <= q30_t'(y_s[CORDIC_STEPS]);
					sin_s[0] <= q30_t'(-x_s[CORDIC_STEPS]);
				end
			endcase
		end
	end

	for (genvar d = 0; d < CORDIC_PAD; d++) begin : g_pad
		always_ff @(posedge clk) begin
			if (en) begin
				sin_s[d+1] <= sin_s[d];
				cos_s[d+1] <= cos_s[d];
			end
		end
	end

	assign sin_v = sin_s[CORDIC_PAD];
	assign cos_v = cos_s[CORDIC_PAD];

endmodule

// ----- sv/urrm_sqrt.sv -----
// ----------------------------------------------------------------------------
// urrm_sqrt - pipelined Q.30 square root
// floor(sqrt(val * 2^30)) by the bitwise integer root, one result bit
// per stage.
// ----------------------------------------------------------------------------
module urrm_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] val,
	output logic [31:0] root
);
	import urrm_pkg::*;

	logic [63:0] n_s   [SQRT_STEPS];
	logic [63:0] res_s [SQRT_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0]   <= 64'(val) << Q;
			res_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
		logic [63:0] trial;
		logic        take;
		assign trial = res_s[i] + BIT;
		assign take  = n_s[i] >= trial;
		always_ff @(posedge clk) begin
			if (en)
				res_s[i+1] <= take ? (res_s[i] >> 1) + BIT : res_s[i] >> 1;
		end
		if (i + 1 < SQRT_STEPS) begin : g_n
			always_ff @(posedge clk) begin
				if (en)
					n_s[i+1] <= take ? n_s[i] - trial : n_s[i];
			end
		end
	end

	assign root = res_s[SQRT_STEPS][31:0];

endmodule

// ----- sv/urrm_matrix.sv -----
// ----------------------------------------------------------------------------
// urrm_matrix - Householder vector and matrix assembly
// Five stages: pole vector, rotated products, sums, outer products,
// final offset with rounding and saturation to the output format.
// ----------------------------------------------------------------------------
module urrm_matrix (
	input  logic                         clk,
	input  logic                         en,
	input  urrm_pkg::q30_t               sin_t,
	input  urrm_pkg::q30_t               cos_t,
	input  urrm_pkg::q30_t               sin_p,
	input  urrm_pkg::q30_t               cos_p,
	input  logic [31:0]                  rad,
	input  logic [31:0]                  vz,
	input  logic [urrm_pkg::FIELD_W-1:0] r22,
	output urrm_pkg::mat_t               mat
);
	import urrm_pkg::*;

	q30_t vx_s1, vy_s1, vz_s1, ct_s1, st_s1;
	q30_t p0_s2, p1_s2, p2_s2, p3_s2;
	q30_t vx_s2, vy_s2, vz_s2, ct_s2, st_s2;
	q30_t sx_s3, sy_s3, vx_s3, vy_s3, vz_s3, ct_s3, st_s3;
	q30_t m_s4 [8];
	q30_t ct_s4, st_s4;
	logic [FIELD_W-1:0] r22_s1, r22_s2, r22_s3, r22_s4;
	logic signed [32:0] sx_sum, sy_sum;

	assign sx_sum = 33'(p0_s2) - 33'(p1_s2);
	assign sy_sum = 33'(p2_s2) + 33'(p3_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s1  <= mulq(sin_p, q30_t'(rad));
			vy_s1  <= mulq(cos_p, q30_t'(rad));
			vz_s1  <= q30_t'(vz);
			ct_s1  <= cos_t;
			st_s1  <= sin_t;
			r22_s1 <= r22;

			p0_s2  <= mulq(vx_s1, ct_s1);
			p1_s2  <= mulq(vy_s1, st_s1);
			p2_s2  <= mulq(vx_s1, st_s1);
			p3_s2  <= mulq(vy_s1, ct_s1);
			vx_s2  <= vx_s1;
			vy_s2  <= vy_s1;
			vz_s2  <= vz_s1;
			ct_s2  <= ct_s1;
			st_s2  <= st_s1;
			r22_s2 <= r22_s1;

			sx_s3  <= q30_t'(sx_sum);
			sy_s3  <= q30_t'(sy_sum);
			vx_s3  <= vx_s2;
			vy_s3  <= vy_s2;
			vz_s3  <= vz_s2;
			ct_s3  <= ct_s2;
			st_s3  <= st_s2;
			r22_s3 <= r22_s2;

			m_s4[0] <= mulq(vx_s3, sx_s3);
			m_s4[1] <= mulq(vx_s3, sy_s3);
			m_s4[2] <= mulq(vx_s3, vz_s3);
			m_s4[3] <= mulq(vy_s3, sx_s3);
			m_s4[4] <= mulq(vy_s3, sy_s3);
			m_s4[5] <= mulq(vy_s3, vz_s3);
			m_s4[6] <= mulq(vz_s3, sx_s3);
			m_s4[7] <= mulq(vz_s3, sy_s3);
			ct_s4   <= ct_s3;
			st_s4   <= st_s3;
			r22_s4  <= r22_s3;

			// subtract the z rotation from V*S
			mat[0] <= to_out(34'(m_s4[0]) - 34'(ct_s4));
			mat[1] <= to_out(34'(m_s4[1]) - 34'(st_s4));
			mat[2] <= to_out(34'(m_s4[2]));
			mat[3] <= to_out(34'(m_s4[3]) + 34'(st_s4));
			mat[4] <= to_out(34'(m_s4[4]) - 34'(ct_s4));
			mat[5] <= to_out(34'(m_s4[5]));
			mat[6] <= to_out(34'(m_s4[6]));
			mat[7] <= to_out(34'(m_s4[7]));
			mat[8] <= r22_s4;
		end
	end

endmodule

// ----- sv/uniform_random_rotation_matrix_unit.sv -----
// ----------------------------------------------------------------------------
// uniform_random_rotation_matrix_unit - random 3x3 rotation matrix
// Builds a uniformly distributed rotation from three uniform fractions by
// a Householder reflection times a rotation about z.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis carries one request: three unsigned fractions
//   (theta turn, pole direction turn, pole magnitude). Master stream m_axis
//   returns the nine matrix entries in row order, signed Q1.14, clipped to
//   plus or minus one.
//   Throughput: one request per cycle, fully pipelined, unless stalled.
//   Latency: 38 register stages. Depth is set by the 32-step square
//   root pipeline (the 24-step CORDIC runs beside it and is padded to
//   match), plus five stages of multiply and assembly.
//   Stall: a skid register behind the last stage takes one result while
//   the receiver holds tready low, as the pipeline makes its last move; after
//   that the whole pipeline holds, nothing is dropped or repeated.
//   Reset: arst_n clears the valid bits and the skid; payload regs are
//   not reset. No state carries from one request to the next.
// ----------------------------------------------------------------------------
module uniform_random_rotation_matrix_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// rand_theta [15:0], rand_phi [31:16], rand_mag [47:32]
	input  logic [47:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// r00, r01, r02, r10, r11, r12, r20, r21, r22, 16 bits each from bit 0
	output logic [143:0] m_axis_tdata
);
	import urrm_pkg::*;

	logic                 adv;
	logic [LATENCY-1:0]   v_s;
	logic [RAND_BITS-1:0] rand_theta, rand_phi, rand_mag;
	logic [31:0]          z30, two_minus_z;
	logic [FIELD_W-1:0]   r22_s [FRONT_DEPTH];
	q30_t                 sin_t, cos_t, sin_p, cos_p;
	logic [31:0]          rad, vz;
	mat_t                 mat_out;
	mat_t                 skid_q;
	logic                 skid_v_q;

	// unpack the request; with RAND_BITS of 16 each field is used in full
	assign rand_theta = s_axis_tdata[RAND_BITS-1:0];
	assign rand_phi   = s_axis_tdata[16+RAND_BITS-1:16];
	assign rand_mag   = s_axis_tdata[32+RAND_BITS-1:32];

	// z = 2*u3 in Q.30, and 2 - z for the pole height
	assign z30         = 32'({rand_mag, 31'b0} >> RAND_BITS);
	assign two_minus_z = (32'd1 << 31) - z30;

	// whole pipeline advances unless the skid already holds a result
	assign adv           = !skid_v_q;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[LATENCY-2:0], s_axis_tvalid};
		end
	end

	// bottom right entry is 1 - z, ready from the input alone; carry it along
	// to the matrix stage input alongside the CORDIC and root outputs
	always_ff @(posedge clk) begin
		if (adv)
			r22_s[0] <= to_out(34'((64'd1 << Q) - 64'(z30)));
	end

	for (genvar d = 1; d < FRONT_DEPTH; d++) begin : g_r22
		always_ff @(posedge clk) begin
			if (adv)
				r22_s[d] <= r22_s[d-1];
		end
	end

	urrm_cordic u_cordic_theta (
		.clk   (clk),
		.en    (adv),
		.turn  (rand_theta),
		.sin_v (sin_t),
		.cos_v (cos_t)
	);

	urrm_cordic u_cordic_phi (
		.clk   (clk),
		.en    (adv),
		.turn  (rand_phi),
		.sin_v (sin_p),
		.cos_v (cos_p)
	);

	urrm_sqrt u_sqrt_rad (
		.clk  (clk),
		.en   (adv),
		.val  (z30),
		.root (rad)
	);

	urrm_sqrt u_sqrt_vz (
		.clk  (clk),
		.en   (adv),
		.val  (two_minus_z),
		.root (vz)
	);

	urrm_matrix u_matrix (
		.clk   (clk),
		.en    (adv),
		.sin_t (sin_t),
		.cos_t (cos_t),
		.sin_p (sin_p),
		.cos_p (cos_p),
		.rad   (rad),
		.vz    (vz),
		.r22   (r22_s[FRONT_DEPTH-1]),
		.mat   (mat_out)
	);

	// skid: catch the last stage when the receiver stalls, release it first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_axis_tready)
				skid_v_q <= 1'b0;
		end else if (v_s[LATENCY-1] && !m_axis_tready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q)
			skid_q <= mat_out;
	end

	assign m_axis_tvalid = skid_v_q || v_s[LATENCY-1];
	assign m_axis_tdata  = skid_v_q ? skid_q : mat_out;

`ifndef ASSERT_OFF
	// a held skid entry keeps its value until taken
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !m_axis_tready |=> skid_v_q && $stable(skid_q))
		else $error("skid entry changed while stalled");

	// the skid only fills from a valid last stage that was refused
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(v_s[LATENCY-1] && !m_axis_tready))
		else $error("skid filled without a stalled result");

	// while the skid is full the last stage must not move
	a_last_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |=> $stable(v_s[LATENCY-1]) || !$past(skid_v_q && !m_axis_tready))
		else $error("last stage moved under a full skid");
`endif

endmodule
